@@ hdl/efork_pkg.sv @@
// ----------------------------------------------------------------------------
// efork_pkg
// Shared types, codes, constants and the step microprogram of the fractional
// EFORK chaos stepper.
// ----------------------------------------------------------------------------
package efork_pkg;

    localparam int MEM_DEPTH_DEF = 256;

    // commands
    localparam logic [1:0] CMD_INIT = 2'd0;
    localparam logic [1:0] CMD_LOAD = 2'd1;
    localparam logic [1:0] CMD_STEP = 2'd2;

    // systems
    localparam logic [1:0] SYS_LORENZ  = 2'd0;
    localparam logic [1:0] SYS_ROSSLER = 2'd1;
    localparam logic [1:0] SYS_CHEN    = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_SYS = 3'd0;
    localparam logic [2:0] CFG_SP  = 3'd1;
    localparam logic [2:0] CFG_A21 = 3'd2;
    localparam logic [2:0] CFG_A31 = 3'd3;
    localparam logic [2:0] CFG_A32 = 3'd4;
    localparam logic [2:0] CFG_W1  = 3'd5;
    localparam logic [2:0] CFG_W2  = 3'd6;
    localparam logic [2:0] CFG_W3  = 3'd7;

    // unit operations
    localparam logic [1:0] OP_NOP = 2'd0;
    localparam logic [1:0] OP_ADD = 2'd1;
    localparam logic [1:0] OP_SUB = 2'd2;
    localparam logic [1:0] OP_MUL = 2'd3;

    // Q12.20 limits and constants
    localparam logic signed [31:0] Q_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN   = 32'sh8000_0000;
    localparam logic signed [31:0] K_SIGMA = 32'sd10485760;
    localparam logic signed [31:0] K_RHO   = 32'sd29360128;
    localparam logic signed [31:0] K_BETA  = 32'sd2796203;
    localparam logic signed [31:0] K_U     = 32'sd7864320;
    localparam logic signed [31:0] K_W     = 32'sd5242880;
    localparam logic signed [31:0] K_WMU   = -32'sd2621440;
    localparam logic signed [31:0] K_AB    = 32'sd209715;
    localparam logic signed [31:0] K_C     = 32'sd5976883;
    localparam logic signed [31:0] K_ONE   = 32'sd1048576;

    // operand codes; codes below WK_N live in the work memory
    localparam logic [5:0] SRC_M0    = 6'd0;
    localparam logic [5:0] SRC_K10   = 6'd3;
    localparam logic [5:0] SRC_K20   = 6'd6;
    localparam logic [5:0] SRC_A0    = 6'd9;
    localparam logic [5:0] SRC_F0    = 6'd12;
    localparam logic [5:0] SRC_T0    = 6'd15;
    localparam logic [5:0] SRC_T1    = 6'd16;
    localparam logic [5:0] WK_N      = 6'd17;
    localparam logic [5:0] SRC_S0    = 6'd17;
    localparam logic [5:0] SRC_S1    = 6'd18;
    localparam logic [5:0] SRC_S2    = 6'd19;
    localparam logic [5:0] SRC_ZERO  = 6'd20;
    localparam logic [5:0] SRC_SP    = 6'd21;
    localparam logic [5:0] SRC_A21   = 6'd22;
    localparam logic [5:0] SRC_A31   = 6'd23;
    localparam logic [5:0] SRC_A32   = 6'd24;
    localparam logic [5:0] SRC_W1    = 6'd25;
    localparam logic [5:0] SRC_W2    = 6'd26;
    localparam logic [5:0] SRC_W3    = 6'd27;
    localparam logic [5:0] SRC_SIGMA = 6'd28;
    localparam logic [5:0] SRC_RHO   = 6'd29;
    localparam logic [5:0] SRC_BETA  = 6'd30;
    localparam logic [5:0] SRC_U     = 6'd31;
    localparam logic [5:0] SRC_W     = 6'd32;
    localparam logic [5:0] SRC_WMU   = 6'd33;
    localparam logic [5:0] SRC_AB    = 6'd34;
    localparam logic [5:0] SRC_C     = 6'd35;
    localparam logic [5:0] SRC_ONE   = 6'd36;

    // program sections
    localparam logic [6:0] P_FLD1   = 7'd3;
    localparam logic [6:0] P_K1     = 7'd13;
    localparam logic [6:0] P_FLD2   = 7'd25;
    localparam logic [6:0] P_K2     = 7'd35;
    localparam logic [6:0] P_FLD3   = 7'd59;
    localparam logic [6:0] P_K3     = 7'd69;
    localparam logic [6:0] PROG_LEN = 7'd93;

    typedef struct packed {
        logic [1:0] op;
        logic [5:0] dst;
        logic [5:0] a;
        logic [5:0] b;
    } uop_t;

    function automatic uop_t mk(input logic [1:0] op, input logic [5:0] dst,
                                input logic [5:0] a, input logic [5:0] b);
        uop_t u;
        u.op  = op;
        u.dst = dst;
        u.a   = a;
        u.b   = b;
        return u;
    endfunction

    // vector field of the argument A0..A2 into F0..F2
    function automatic uop_t field_uop(input logic [1:0] sys, input logic [3:0] k);
        uop_t u;
        u = mk(OP_NOP, SRC_T0, SRC_ZERO, SRC_ZERO);
        case (sys)
            SYS_ROSSLER: begin
                case (k)
                    4'd0: u = mk(OP_SUB, SRC_T0, SRC_ZERO, SRC_A0 + 6'd1);
                    4'd1: u = mk(OP_SUB, SRC_F0, SRC_T0, SRC_A0 + 6'd2);
                    4'd2: u = mk(OP_MUL, SRC_T0, SRC_AB, SRC_A0 + 6'd1);
                    4'd3: u = mk(OP_ADD, SRC_F0 + 6'd1, SRC_A0, SRC_T0);
                    4'd4: u = mk(OP_SUB, SRC_T0, SRC_A0, SRC_C);
                    4'd5: u = mk(OP_MUL, SRC_T0, SRC_A0 + 6'd2, SRC_T0);
                    4'd6: u = mk(OP_ADD, SRC_F0 + 6'd2, SRC_AB, SRC_T0);
                    default: u = mk(OP_NOP, SRC_T0, SRC_ZERO, SRC_ZERO);
                endcase
            end
            SYS_CHEN: begin
                case (k)
                    4'd0: u = mk(OP_SUB, SRC_T0, SRC_A0 + 6'd1, SRC_A0);
                    4'd1: u = mk(OP_MUL, SRC_F0, SRC_U, SRC_T0);
                    4'd2: u = mk(OP_MUL, SRC_T0, SRC_WMU, SRC_A0);
                    4'd3: u = mk(OP_MUL, SRC_T1, SRC_A0, SRC_A0 + 6'd2);
                    4'd4: u = mk(OP_SUB, SRC_T0, SRC_T0, SRC_T1);
                    4'd5: u = mk(OP_MUL, SRC_T1, SRC_W, SRC_A0 + 6'd1);
                    4'd6: u = mk(OP_ADD, SRC_F0 + 6'd1, SRC_T0, SRC_T1);
                    4'd7: u = mk(OP_MUL, SRC_T0, SRC_A0, SRC_A0 + 6'd1);
                    4'd8: u = mk(OP_MUL, SRC_T1, SRC_ONE, SRC_A0 + 6'd2);
                    4'd9: u = mk(OP_SUB, SRC_F0 + 6'd2, SRC_T0, SRC_T1);
                    default: u = mk(OP_NOP, SRC_T0, SRC_ZERO, SRC_ZERO);
                endcase
            end
            default: begin
                case (k)
                    4'd0: u = mk(OP_SUB, SRC_T0, SRC_A0 + 6'd1, SRC_A0);
                    4'd1: u = mk(OP_MUL, SRC_F0, SRC_SIGMA, SRC_T0);
                    4'd2: u = mk(OP_SUB, SRC_T0, SRC_RHO, SRC_A0 + 6'd2);
                    4'd3: u = mk(OP_MUL, SRC_T0, SRC_A0, SRC_T0);
                    4'd4: u = mk(OP_SUB, SRC_F0 + 6'd1, SRC_T0, SRC_A0 + 6'd1);
                    4'd5: u = mk(OP_MUL, SRC_T0, SRC_A0, SRC_A0 + 6'd1);
                    4'd6: u = mk(OP_MUL, SRC_T1, SRC_BETA, SRC_A0 + 6'd2);
                    4'd7: u = mk(OP_SUB, SRC_F0 + 6'd2, SRC_T0, SRC_T1);
                    default: u = mk(OP_NOP, SRC_T0, SRC_ZERO, SRC_ZERO);
                endcase
            end
        endcase
        return u;
    endfunction

    // one three-stage step after the memory sums are in M0..M2
    function automatic uop_t prog_uop(input logic [1:0] sys, input logic [6:0] pc);
        logic [6:0] k;
        logic [5:0] i;
        uop_t u;
        u = mk(OP_NOP, SRC_T0, SRC_ZERO, SRC_ZERO);
        k = 7'd0;
        i = 6'd0;
        if (pc < P_FLD1) begin
            i = {4'd0, pc[1:0]};
            u = mk(OP_ADD, SRC_A0 + i, SRC_S0 + i, SRC_ZERO);
        end else if (pc < P_K1) begin
            u = field_uop(sys, 4'(pc - P_FLD1));
        end else if (pc < P_FLD2) begin
            k = pc - P_K1;
            i = {4'd0, k[3:2]};
            case (k[1:0])
                2'd0: u = mk(OP_SUB, SRC_T0, SRC_F0 + i, SRC_M0 + i);
                2'd1: u = mk(OP_MUL, SRC_K10 + i, SRC_SP, SRC_T0);
                2'd2: u = mk(OP_MUL, SRC_T0, SRC_A21, SRC_K10 + i);
                default: u = mk(OP_ADD, SRC_A0 + i, SRC_S0 + i, SRC_T0);
            endcase
        end else if (pc < P_K2) begin
            u = field_uop(sys, 4'(pc - P_FLD2));
        end else if (pc < P_FLD3) begin
            k = pc - P_K2;
            i = {4'd0, k[4:3]};
            case (k[2:0])
                3'd0: u = mk(OP_MUL, SRC_K20 + i, SRC_SP, SRC_F0 + i);
                3'd1: u = mk(OP_MUL, SRC_T0, SRC_A31, SRC_K20 + i);
                3'd2: u = mk(OP_ADD, SRC_T0, SRC_S0 + i, SRC_T0);
                3'd3: u = mk(OP_MUL, SRC_T1, SRC_A32, SRC_K10 + i);
                3'd4: u = mk(OP_ADD, SRC_A0 + i, SRC_T0, SRC_T1);
                default: u = mk(OP_NOP, SRC_T0, SRC_ZERO, SRC_ZERO);
            endcase
        end else if (pc < P_K3) begin
            u = field_uop(sys, 4'(pc - P_FLD3));
        end else if (pc < PROG_LEN) begin
            k = pc - P_K3;
            i = {4'd0, k[4:3]};
            case (k[2:0])
                3'd0: u = mk(OP_MUL, SRC_T1, SRC_W1, SRC_K10 + i);
                3'd1: u = mk(OP_ADD, SRC_A0 + i, SRC_S0 + i, SRC_T1);
                3'd2: u = mk(OP_MUL, SRC_T1, SRC_W2, SRC_K20 + i);
                3'd3: u = mk(OP_ADD, SRC_A0 + i, SRC_A0 + i, SRC_T1);
                3'd4: u = mk(OP_MUL, SRC_T1, SRC_SP, SRC_F0 + i);
                3'd5: u = mk(OP_MUL, SRC_T1, SRC_W3, SRC_T1);
                3'd6: u = mk(OP_ADD, SRC_A0 + i, SRC_A0 + i, SRC_T1);
                default: u = mk(OP_SUB, SRC_M0 + i, SRC_A0 + i, SRC_S0 + i);
            endcase
        end
        return u;
    endfunction

endpackage

@@ hdl/efork_arith.sv @@
// ----------------------------------------------------------------------------
// efork_arith
// Shared Q12.20 unit: registered 32x32 product or sum, then rounding and
// saturation.
// ----------------------------------------------------------------------------
module efork_arith (
    input  logic               aclk,
    input  logic [1:0]         op,
    input  logic signed [31:0] op_a,
    input  logic signed [31:0] op_b,
    output logic signed [31:0] result,
    output logic signed [43:0] prod_rnd
);

    logic signed [63:0] prod_reg;
    logic signed [32:0] sum_reg;
    logic [1:0]         op_reg;
    logic signed [63:0] prod_bias;

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
        sum_reg  <= (op == efork_pkg::OP_SUB) ? 33'(op_a) - 33'(op_b)
                                              : 33'(op_a) + 33'(op_b);
        op_reg   <= op;
    end

    assign prod_bias = prod_reg + 64'sd524288;
    assign prod_rnd  = prod_bias[63:20];

    always_comb begin
        if (op_reg == efork_pkg::OP_MUL) begin
            if (prod_rnd > 44'(efork_pkg::Q_MAX)) begin
                result = efork_pkg::Q_MAX;
            end else if (prod_rnd < 44'(efork_pkg::Q_MIN)) begin
                result = efork_pkg::Q_MIN;
            end else begin
                result = prod_rnd[31:0];
            end
        end else begin
            if (sum_reg > 33'(efork_pkg::Q_MAX)) begin
                result = efork_pkg::Q_MAX;
            end else if (sum_reg < 33'(efork_pkg::Q_MIN)) begin
                result = efork_pkg::Q_MIN;
            end else begin
                result = sum_reg[31:0];
            end
        end
    end

endmodule

@@ hdl/fractional_chaos_efork_step_core.sv @@
// ----------------------------------------------------------------------------
// fractional_chaos_efork_step_core
// Fractional-order Lorenz / Rossler / Chen oscillator, one EFORK step per
// advance request, on one shared multiply/add unit under a microsequencer.
// ----------------------------------------------------------------------------
// Advance request: three passes of memory sums over the filled history (one lag
// per cycle on the shared multiplier), then the 93-op microprogram, each op in
// read, execute and write-back states, then commit. Init and weight-load requests
// complete without leaving idle. After reset the lag weight table is cleared,
// during which no request is taken; configuration writes are taken at any time.
module fractional_chaos_efork_step_core #(
    parameter int MEM_DEPTH = efork_pkg::MEM_DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_cmd,
    input  logic signed [31:0] s_x_in,
    input  logic signed [31:0] s_y_in,
    input  logic signed [31:0] s_z_in,
    input  logic [7:0]         s_lag_index,
    input  logic signed [31:0] s_lag_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_x_out,
    output logic signed [31:0] m_y_out,
    output logic signed [31:0] m_z_out,
    output logic [31:0]        m_step_number,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam int AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int CW    = $clog2(MEM_DEPTH + 1);
    localparam int ACC_W = 44 + CW;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_MEM    = 3'd2;
    localparam logic [2:0] ST_RD     = 3'd3;
    localparam logic [2:0] ST_EX     = 3'd4;
    localparam logic [2:0] ST_WB     = 3'd5;
    localparam logic [2:0] ST_COMMIT = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [AW-1:0] clr_reg;

    logic [1:0]         sys_reg;
    logic signed [31:0] sp_reg, a21_reg, a31_reg, a32_reg, w1_reg, w2_reg, w3_reg;
    logic signed [31:0] x_now_reg, y_now_reg, z_now_reg;
    logic [AW-1:0]      head_reg;
    logic [CW-1:0]      fill_reg;
    logic [31:0]        count_reg;

    logic signed [31:0] wt_mem [0:MEM_DEPTH-1];
    logic signed [31:0] xh_mem [0:MEM_DEPTH-1];
    logic signed [31:0] yh_mem [0:MEM_DEPTH-1];
    logic signed [31:0] zh_mem [0:MEM_DEPTH-1];
    logic signed [31:0] wk_mem [0:31];

    logic [1:0]              pass_reg;
    logic [CW-1:0]           cnt_reg;
    logic [AW-1:0]           rptr_reg;
    logic                    rdv_reg, prv_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [31:0]      wt_rd_reg, xh_rd_reg, yh_rd_reg, zh_rd_reg;

    logic [6:0]            pc_reg;
    efork_pkg::uop_t       uop_cur, uop_reg;
    logic signed [31:0]    ra_reg, rb_reg, oa_reg, ob_reg;
    logic                  ma_reg, mb_reg;
    logic signed [31:0]    dif_reg [0:2];
    logic signed [31:0]    nxt_reg [0:2];

    logic                  m_valid_reg;
    logic signed [31:0]    x_out_reg, y_out_reg, z_out_reg;
    logic [31:0]           step_out_reg;

    logic                  s_fire, issue, mem_done, commit_fire;
    logic                  wt_we;
    logic [AW-1:0]         wt_wa, rptr_start;
    logic signed [31:0]    wt_wd, hist_sel, acc_sat;
    logic                  wk_we;
    logic [4:0]            wk_wa;
    logic signed [31:0]    wk_wd;
    logic [1:0]            unit_op;
    logic signed [31:0]    unit_a, unit_b, unit_res;
    logic signed [43:0]    unit_rnd;

    function automatic logic signed [31:0] src_other(input logic [5:0] code);
        logic signed [31:0] v;
        case (code)
            efork_pkg::SRC_S0:    v = x_now_reg;
            efork_pkg::SRC_S1:    v = y_now_reg;
            efork_pkg::SRC_S2:    v = z_now_reg;
            efork_pkg::SRC_SP:    v = sp_reg;
            efork_pkg::SRC_A21:   v = a21_reg;
            efork_pkg::SRC_A31:   v = a31_reg;
            efork_pkg::SRC_A32:   v = a32_reg;
            efork_pkg::SRC_W1:    v = w1_reg;
            efork_pkg::SRC_W2:    v = w2_reg;
            efork_pkg::SRC_W3:    v = w3_reg;
            efork_pkg::SRC_SIGMA: v = efork_pkg::K_SIGMA;
            efork_pkg::SRC_RHO:   v = efork_pkg::K_RHO;
            efork_pkg::SRC_BETA:  v = efork_pkg::K_BETA;
            efork_pkg::SRC_U:     v = efork_pkg::K_U;
            efork_pkg::SRC_W:     v = efork_pkg::K_W;
            efork_pkg::SRC_WMU:   v = efork_pkg::K_WMU;
            efork_pkg::SRC_AB:    v = efork_pkg::K_AB;
            efork_pkg::SRC_C:     v = efork_pkg::K_C;
            efork_pkg::SRC_ONE:   v = efork_pkg::K_ONE;
            default:              v = 32'sd0;
        endcase
        return v;
    endfunction

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign s_fire    = s_valid && s_ready;

    assign m_valid       = m_valid_reg;
    assign m_x_out       = x_out_reg;
    assign m_y_out       = y_out_reg;
    assign m_z_out       = z_out_reg;
    assign m_step_number = step_out_reg;

    assign uop_cur     = efork_pkg::prog_uop(sys_reg, pc_reg);
    assign issue       = (cnt_reg < fill_reg);
    assign mem_done    = (state_reg == ST_MEM) && !issue && !rdv_reg && !prv_reg;
    assign commit_fire = (state_reg == ST_COMMIT) && (!m_valid_reg || m_ready);
    assign rptr_start  = (head_reg == '0) ? AW'(MEM_DEPTH - 1) : head_reg - 1'b1;

    always_comb begin
        case (pass_reg)
            2'd0:    hist_sel = xh_rd_reg;
            2'd1:    hist_sel = yh_rd_reg;
            default: hist_sel = zh_rd_reg;
        endcase
    end

    always_comb begin
        if (acc_reg > ACC_W'(efork_pkg::Q_MAX)) begin
            acc_sat = efork_pkg::Q_MAX;
        end else if (acc_reg < ACC_W'(efork_pkg::Q_MIN)) begin
            acc_sat = efork_pkg::Q_MIN;
        end else begin
            acc_sat = acc_reg[31:0];
        end
    end

    // shared unit operand select
    always_comb begin
        if (state_reg == ST_MEM) begin
            unit_op = efork_pkg::OP_MUL;
            unit_a  = wt_rd_reg;
            unit_b  = hist_sel;
        end else begin
            unit_op = uop_reg.op;
            unit_a  = ma_reg ? ra_reg : oa_reg;
            unit_b  = mb_reg ? rb_reg : ob_reg;
        end
    end

    efork_arith u_arith (
        .aclk     (aclk),
        .op       (unit_op),
        .op_a     (unit_a),
        .op_b     (unit_b),
        .result   (unit_res),
        .prod_rnd (unit_rnd)
    );

    // lag weight table
    always_comb begin
        wt_we = 1'b0;
        wt_wa = clr_reg;
        wt_wd = 32'sd0;
        if (state_reg == ST_CLEAR) begin
            wt_we = 1'b1;
        end else if (s_fire && s_cmd == efork_pkg::CMD_LOAD
                     && 32'(s_lag_index) < 32'(MEM_DEPTH)) begin
            wt_we = 1'b1;
            wt_wa = AW'(s_lag_index);
            wt_wd = s_lag_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (wt_we) begin
            wt_mem[wt_wa] <= wt_wd;
        end
        wt_rd_reg <= wt_mem[cnt_reg[AW-1:0]];
    end

    // difference history
    always_ff @(posedge aclk) begin
        if (commit_fire) begin
            xh_mem[head_reg] <= dif_reg[0];
            yh_mem[head_reg] <= dif_reg[1];
            zh_mem[head_reg] <= dif_reg[2];
        end
        xh_rd_reg <= xh_mem[rptr_reg];
        yh_rd_reg <= yh_mem[rptr_reg];
        zh_rd_reg <= zh_mem[rptr_reg];
    end

    // work memory
    always_comb begin
        wk_we = 1'b0;
        wk_wa = uop_reg.dst[4:0];
        wk_wd = unit_res;
        if (mem_done) begin
            wk_we = 1'b1;
            wk_wa = 5'(efork_pkg::SRC_M0) + 5'(pass_reg);
            wk_wd = acc_sat;
        end else if (state_reg == ST_WB && uop_reg.op != efork_pkg::OP_NOP) begin
            wk_we = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wk_we) begin
            wk_mem[wk_wa] <= wk_wd;
        end
        ra_reg <= wk_mem[uop_cur.a[4:0]];
        rb_reg <= wk_mem[uop_cur.b[4:0]];
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (state_reg == ST_RD) begin
            uop_reg <= uop_cur;
            oa_reg  <= src_other(uop_cur.a);
            ob_reg  <= src_other(uop_cur.b);
            ma_reg  <= (uop_cur.a < efork_pkg::WK_N);
            mb_reg  <= (uop_cur.b < efork_pkg::WK_N);
        end
        if (state_reg == ST_IDLE || mem_done) begin
            acc_reg <= '0;
        end else if (prv_reg) begin
            acc_reg <= acc_reg + ACC_W'(unit_rnd);
        end
        for (int i = 0; i < 3; i++) begin
            if (wk_we && wk_wa == 5'(efork_pkg::SRC_M0) + 5'(i)) begin
                dif_reg[i] <= wk_wd;
            end
            if (wk_we && wk_wa == 5'(efork_pkg::SRC_A0) + 5'(i)) begin
                nxt_reg[i] <= wk_wd;
            end
        end
        if (commit_fire) begin
            x_out_reg    <= nxt_reg[0];
            y_out_reg    <= nxt_reg[1];
            z_out_reg    <= nxt_reg[2];
            step_out_reg <= count_reg + 32'd1;
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:  if (clr_reg == AW'(MEM_DEPTH - 1)) state_next = ST_IDLE;
            ST_IDLE:   if (s_fire && s_cmd == efork_pkg::CMD_STEP) state_next = ST_MEM;
            ST_MEM:    if (mem_done && pass_reg == 2'd2) state_next = ST_RD;
            ST_RD:     state_next = ST_EX;
            ST_EX:     state_next = ST_WB;
            ST_WB: begin
                state_next = (pc_reg == efork_pkg::PROG_LEN - 7'd1) ? ST_COMMIT : ST_RD;
            end
            ST_COMMIT: if (commit_fire) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            sys_reg     <= efork_pkg::SYS_LORENZ;
            sp_reg      <= '0;
            a21_reg     <= '0;
            a31_reg     <= '0;
            a32_reg     <= '0;
            w1_reg      <= '0;
            w2_reg      <= '0;
            w3_reg      <= '0;
            x_now_reg   <= '0;
            y_now_reg   <= '0;
            z_now_reg   <= '0;
            head_reg    <= '0;
            fill_reg    <= '0;
            count_reg   <= '0;
            pass_reg    <= '0;
            cnt_reg     <= '0;
            rptr_reg    <= '0;
            rdv_reg     <= 1'b0;
            prv_reg     <= 1'b0;
            pc_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    efork_pkg::CFG_SYS: sys_reg <= cfg_data[1:0];
                    efork_pkg::CFG_SP:  sp_reg  <= cfg_data;
                    efork_pkg::CFG_A21: a21_reg <= cfg_data;
                    efork_pkg::CFG_A31: a31_reg <= cfg_data;
                    efork_pkg::CFG_A32: a32_reg <= cfg_data;
                    efork_pkg::CFG_W1:  w1_reg  <= cfg_data;
                    efork_pkg::CFG_W2:  w2_reg  <= cfg_data;
                    efork_pkg::CFG_W3:  w3_reg  <= cfg_data;
                    default: ;
                endcase
            end

            if (state_reg == ST_CLEAR) begin
                clr_reg <= clr_reg + 1'b1;
            end

            if (s_fire && s_cmd == efork_pkg::CMD_INIT) begin
                x_now_reg <= s_x_in;
                y_now_reg <= s_y_in;
                z_now_reg <= s_z_in;
                head_reg  <= '0;
                fill_reg  <= '0;
                count_reg <= '0;
            end

            if (s_fire && s_cmd == efork_pkg::CMD_STEP) begin
                pass_reg <= 2'd0;
                cnt_reg  <= '0;
                rptr_reg <= rptr_start;
            end

            if (state_reg == ST_MEM) begin
                rdv_reg <= issue;
                prv_reg <= rdv_reg;
                if (issue) begin
                    cnt_reg  <= cnt_reg + 1'b1;
                    rptr_reg <= (rptr_reg == '0) ? AW'(MEM_DEPTH - 1) : rptr_reg - 1'b1;
                end
                if (mem_done) begin
                    pass_reg <= pass_reg + 2'd1;
                    cnt_reg  <= '0;
                    rptr_reg <= rptr_start;
                    pc_reg   <= '0;
                end
            end

            if (state_reg == ST_WB) begin
                pc_reg <= pc_reg + 7'd1;
            end

            if (commit_fire) begin
                x_now_reg   <= nxt_reg[0];
                y_now_reg   <= nxt_reg[1];
                z_now_reg   <= nxt_reg[2];
                head_reg    <= (head_reg == AW'(MEM_DEPTH - 1)) ? '0 : head_reg + 1'b1;
                if (fill_reg < CW'(MEM_DEPTH)) begin
                    fill_reg <= fill_reg + 1'b1;
                end
                count_reg   <= count_reg + 32'd1;
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

@@ hdl/efork_checker.sv @@
// ----------------------------------------------------------------------------
// efork_checker
// Port-level checks of the EFORK stepper, bound to the top level.
// ----------------------------------------------------------------------------
module efork_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [1:0]  s_cmd,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_step_number
);

    // hold a stalled result
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_step_number))
        else $error("result dropped or changed while stalled");

    // drop ready while a step is in progress
    a_step_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_cmd == efork_pkg::CMD_STEP |=> !s_ready)
        else $error("ready high right after step request");

    a_short_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_cmd != efork_pkg::CMD_STEP |=> s_ready)
        else $error("ready dropped after non-step request");

    a_result_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("result appeared without a step in progress");

endmodule

bind fractional_chaos_efork_step_core efork_checker u_efork_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_cmd         (s_cmd),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_step_number (m_step_number)
);
